// File: hdl/stl_pkg.sv
// ----------------------------------------------------------------------------
// stl_pkg
// Shared types and constants for the script token lexer.
// ----------------------------------------------------------------------------
package stl_pkg;

	localparam int LINE_BITS = 20;
	localparam int COLUMN_BITS = 16;
	localparam int KEYWORD_CHARS = 8;
	localparam int COUNT_BITS = 16;
	localparam int VALUE_BITS = 31;
	localparam int KIND_BITS = 6;
	localparam int MAX_RES = 3;

	localparam logic [KIND_BITS-1:0] K_IDENT = 6'd0;
	localparam logic [KIND_BITS-1:0] K_NUMBER = 6'd1;
	localparam logic [KIND_BITS-1:0] K_END = 6'd35;
	localparam logic [KIND_BITS-1:0] K_ERROR = 6'd36;

	typedef enum logic [2:0] {
		M_IDLE, M_PEND, M_NUMBER, M_IDENT, M_COMMENT, M_CSLASH, M_ERROR
	} mode_t;

	typedef struct packed {
		logic [KIND_BITS-1:0] kind;
		logic [LINE_BITS-1:0] line;
		logic [COLUMN_BITS-1:0] col;
		logic [COUNT_BITS-1:0] len;
		logic [VALUE_BITS-1:0] value;
		logic ovf;
		logic [7:0] bad;
	} tok_t;

	typedef struct packed {
		logic [MAX_RES-1:0] vld;
		tok_t [MAX_RES-1:0] tok;
	} tok_set_t;

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
	endfunction

	function automatic logic is_ws(input logic [7:0] c);
		return c == 8'h20 || c == 8'h09 || c == 8'h0d || c == 8'h0a;
	endfunction

	function automatic logic is_pend(input logic [7:0] c);
		return c == "=" || c == "!" || c == "<" || c == ">" || c == "&" ||
			c == "|" || c == "+" || c == "-" || c == "/";
	endfunction

	// single operator kinds; error for unknown
	function automatic logic [KIND_BITS-1:0] single_kind(input logic [7:0] c);
		logic [KIND_BITS-1:0] k;
		k = K_ERROR;
		unique case (c)
			";": k = 6'd20;
			"{": k = 6'd21;
			"}": k = 6'd22;
			"(": k = 6'd23;
			")": k = 6'd24;
			".": k = 6'd25;
			"*": k = 6'd29;
			"%": k = 6'd31;
			default: k = K_ERROR;
		endcase
		return k;
	endfunction

	function automatic logic [KIND_BITS-1:0] held_kind(input logic [7:0] c);
		logic [KIND_BITS-1:0] k;
		k = K_ERROR;
		unique case (c)
			"=": k = 6'd26;
			"!": k = 6'd34;
			"<": k = 6'd32;
			">": k = 6'd33;
			"+": k = 6'd27;
			"-": k = 6'd28;
			"/": k = 6'd30;
			default: k = K_ERROR;
		endcase
		return k;
	endfunction

	// zero when no pair
	function automatic logic [KIND_BITS-1:0] pair_kind(input logic [7:0] h,
			input logic [7:0] c);
		logic [KIND_BITS-1:0] k;
		k = '0;
		if (c == "=") begin
			unique case (h)
				"=": k = 6'd12;
				"!": k = 6'd13;
				"<": k = 6'd14;
				">": k = 6'd15;
				"+": k = 6'd18;
				"-": k = 6'd19;
				default: k = '0;
			endcase
		end else if (h == "&" && c == "&") begin
			k = 6'd16;
		end else if (h == "|" && c == "|") begin
			k = 6'd17;
		end
		return k;
	endfunction

	function automatic logic [KIND_BITS-1:0] word_kind(
			input logic [KEYWORD_CHARS*8-1:0] w, input logic [COUNT_BITS-1:0] n);
		logic [63:0] p;
		logic [KIND_BITS-1:0] k;
		p = w[63:0];
		k = K_IDENT;
		// prefix bytes are little-endian: char 0 in bits 7:0
		if (n == 16'd3 && p == 64'h74656c) k = 6'd2;
		else if (n == 16'd2 && p == 64'h6669) k = 6'd3;
		else if (n == 16'd4 && p == 64'h65736c65) k = 6'd4;
		else if (n == 16'd3 && p == 64'h726f66) k = 6'd5;
		else if (n == 16'd2 && p == 64'h6e69) k = 6'd6;
		else if (n == 16'd5 && p == 64'h656c696877) k = 6'd7;
		else if (n == 16'd5 && p == 64'h6b61657262) k = 6'd8;
		else if (n == 16'd8 && p == 64'h65756e69746e6f63) k = 6'd9;
		else if (n == 16'd6 && p == 64'h6e7275746572) k = 6'd10;
		else if (n == 16'd4 && p == 64'h656e6f6e) k = 6'd11;
		else if (n == 16'd3 && p == 64'h646e61) k = 6'd16;
		else if (n == 16'd2 && p == 64'h726f) k = 6'd17;
		else if (n == 16'd3 && p == 64'h746f6e) k = 6'd34;
		return k;
	endfunction

endpackage

// File: hdl/script_token_lexer.sv
// ----------------------------------------------------------------------------
// script_token_lexer
// Streaming lexer: one source byte per item in, tokens out.
// ----------------------------------------------------------------------------
// One character per cycle while the output accepts: an item is taken whenever the result
// register is free or is being emptied in the same cycle. An item gives up to three
// tokens, delivered one per cycle from the result register while the output is ready,
// and the next item is held until the last of an item's tokens drains; items with at
// most one token stream at one per cycle.
module script_token_lexer
	import stl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // ch[7:0]
	input  logic        s_tuser,  // has_char
	input  logic        s_tlast,  // end_of_source
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,  // start_line, start_column, token_length,
	                              // number_value, overflowed, bad_char, zero
	output logic [5:0]  m_tuser,  // kind
	output logic        m_tlast   // run_last
);

	mode_t mode_q, mode_d;
	logic [7:0] held_q, held_d;
	logic [LINE_BITS-1:0] cline_q, cline_d, tline_q, tline_d;
	logic [COLUMN_BITS-1:0] ccol_q, ccol_d, tcol_q, tcol_d;
	logic [COUNT_BITS-1:0] cnt_q, cnt_d;
	logic [VALUE_BITS-1:0] acc_q, acc_d;
	logic clamp_q, clamp_d;
	logic [KEYWORD_CHARS*8-1:0] word_q, word_d;

	logic [7:0] c;
	logic has, eos, take, empty_next;
	tok_set_t set_d;
	tok_t otok;
	logic [1:0] n;
	logic [35:0] mul;
	logic start;
	logic [KIND_BITS-1:0] pk, sk;

	assign c = s_tdata;
	assign has = s_tuser;
	assign eos = s_tlast;
	assign s_tready = empty_next;
	assign take = s_tvalid && s_tready;

	function automatic tok_t mk(input logic [KIND_BITS-1:0] k,
			input logic [LINE_BITS-1:0] l, input logic [COLUMN_BITS-1:0] col,
			input logic [COUNT_BITS-1:0] len, input logic [VALUE_BITS-1:0] v,
			input logic o, input logic [7:0] b);
		tok_t t;
		t.kind = k; t.line = l; t.col = col; t.len = len;
		t.value = v; t.ovf = o; t.bad = b;
		return t;
	endfunction

	assign mul = {5'd0, acc_q} * 36'd10 + {32'd0, c[3:0]};
	assign pk = pair_kind(held_q, c);
	assign sk = single_kind(c);

	always_comb begin
		mode_d = mode_q; held_d = held_q; cline_d = cline_q; ccol_d = ccol_q;
		tline_d = tline_q; tcol_d = tcol_q; cnt_d = cnt_q; acc_d = acc_q;
		clamp_d = clamp_q; word_d = word_q;
		set_d = '0; n = 2'd0; start = 1'b0;
		if (has) begin
			unique case (mode_q)
				M_NUMBER: begin
					if (is_digit(c)) begin
						if (mul > 36'd2147483647) begin
							acc_d = 31'h7fffffff; clamp_d = 1'b1;
						end else begin
							acc_d = mul[VALUE_BITS-1:0];
						end
						if (cnt_q != '1) cnt_d = cnt_q + 1'b1;
					end else begin
						set_d.tok[n] = mk(K_NUMBER, tline_q, tcol_q, cnt_q, acc_q,
							clamp_q, 8'd0);
						set_d.vld[n] = 1'b1; n = n + 2'd1; start = 1'b1;
					end
				end
				M_IDENT: begin
					if (is_alpha(c) || is_digit(c)) begin
						if (cnt_q < COUNT_BITS'(KEYWORD_CHARS))
							word_d[cnt_q[2:0]*8 +: 8] = c;
						if (cnt_q != '1) cnt_d = cnt_q + 1'b1;
					end else begin
						set_d.tok[n] = mk(word_kind(word_q, cnt_q), tline_q, tcol_q,
							cnt_q, '0, 1'b0, 8'd0);
						set_d.vld[n] = 1'b1; n = n + 2'd1; start = 1'b1;
					end
				end
				M_PEND: begin
					if (pk != '0) begin
						set_d.tok[n] = mk(pk, tline_q, tcol_q, 16'd2, '0, 1'b0, 8'd0);
						set_d.vld[n] = 1'b1; n = n + 2'd1; mode_d = M_IDLE;
					end else if (held_q == "/" && c == "/") begin
						mode_d = M_COMMENT;
					end else if (held_kind(held_q) == K_ERROR) begin
						set_d.tok[n] = mk(K_ERROR, tline_q, tcol_q, 16'd1, '0, 1'b0,
							held_q);
						set_d.vld[n] = 1'b1; n = n + 2'd1; mode_d = M_ERROR;
					end else begin
						set_d.tok[n] = mk(held_kind(held_q), tline_q, tcol_q, 16'd1,
							'0, 1'b0, 8'd0);
						set_d.vld[n] = 1'b1; n = n + 2'd1; start = 1'b1;
					end
				end
				M_COMMENT, M_CSLASH: begin
					if (c == 8'h0a) mode_d = M_IDLE;
					else if (c == "/") mode_d = (mode_q == M_CSLASH) ? M_IDLE : M_CSLASH;
					else mode_d = M_COMMENT;
				end
				M_ERROR: ;
				default: start = 1'b1;
			endcase
			if (start) begin
				mode_d = M_IDLE;
				if (is_ws(c)) begin
				end else if (is_digit(c)) begin
					tline_d = cline_q; tcol_d = ccol_q; cnt_d = 16'd1;
					acc_d = {27'd0, c[3:0]}; clamp_d = 1'b0; mode_d = M_NUMBER;
				end else if (is_alpha(c)) begin
					tline_d = cline_q; tcol_d = ccol_q; cnt_d = 16'd1;
					word_d = {{(KEYWORD_CHARS*8-8){1'b0}}, c}; mode_d = M_IDENT;
				end else if (is_pend(c)) begin
					tline_d = cline_q; tcol_d = ccol_q; cnt_d = 16'd1;
					held_d = c; mode_d = M_PEND;
				end else if (sk == K_ERROR) begin
					set_d.tok[n] = mk(K_ERROR, cline_q, ccol_q, 16'd1, '0, 1'b0, c);
					set_d.vld[n] = 1'b1; n = n + 2'd1; mode_d = M_ERROR;
				end else begin
					set_d.tok[n] = mk(sk, cline_q, ccol_q, 16'd1, '0, 1'b0, 8'd0);
					set_d.vld[n] = 1'b1; n = n + 2'd1;
				end
			end
			if (c == 8'h0a) begin
				if (cline_q != '1) cline_d = cline_q + 1'b1;
				ccol_d = COLUMN_BITS'(1);
			end else if (ccol_q != '1) begin
				ccol_d = ccol_q + 1'b1;
			end
		end
		if (eos) begin
			unique case (mode_d)
				M_NUMBER: begin
					set_d.tok[n] = mk(K_NUMBER, tline_d, tcol_d, cnt_d, acc_d,
						clamp_d, 8'd0);
					set_d.vld[n] = 1'b1; n = n + 2'd1;
				end
				M_IDENT: begin
					set_d.tok[n] = mk(word_kind(word_d, cnt_d), tline_d, tcol_d,
						cnt_d, '0, 1'b0, 8'd0);
					set_d.vld[n] = 1'b1; n = n + 2'd1;
				end
				M_PEND: begin
					set_d.tok[n] = mk(held_kind(held_d), tline_d, tcol_d, 16'd1, '0,
						1'b0, (held_kind(held_d) == K_ERROR) ? held_d : 8'd0);
					set_d.vld[n] = 1'b1; n = n + 2'd1;
				end
				default: ;
			endcase
			set_d.tok[n] = mk(K_END, cline_d, ccol_d, '0, '0, 1'b0, 8'd0);
			set_d.vld[n] = 1'b1;
			mode_d = M_IDLE; held_d = '0; cline_d = LINE_BITS'(1);
			ccol_d = COLUMN_BITS'(1); tline_d = LINE_BITS'(1);
			tcol_d = COLUMN_BITS'(1); cnt_d = '0; acc_d = '0; clamp_d = 1'b0;
			word_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE; held_q <= '0; cline_q <= LINE_BITS'(1);
			ccol_q <= COLUMN_BITS'(1); tline_q <= LINE_BITS'(1);
			tcol_q <= COLUMN_BITS'(1); cnt_q <= '0; acc_q <= '0;
			clamp_q <= 1'b0; word_q <= '0;
		end else if (take) begin
			mode_q <= mode_d; held_q <= held_d; cline_q <= cline_d;
			ccol_q <= ccol_d; tline_q <= tline_d; tcol_q <= tcol_d;
			cnt_q <= cnt_d; acc_q <= acc_d; clamp_q <= clamp_d; word_q <= word_d;
		end
	end

	stl_out_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (take && set_d.vld[0]),
		.set_in     (set_d),
		.empty_next (empty_next),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_tok    (otok),
		.out_last   (m_tlast)
	);

	assign m_tuser = otok.kind;
	assign m_tdata = {4'd0, otok.bad, otok.ovf, otok.value, otok.len, otok.col,
		otok.line};

endmodule

// File: hdl/stl_out_queue.sv
// ----------------------------------------------------------------------------
// stl_out_queue
// Holds up to three tokens of one step and drains them one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module stl_out_queue
	import stl_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     load,
	input  tok_set_t set_in,
	output logic     empty_next,
	output logic     out_valid,
	input  logic     out_ready,
	output tok_t     out_tok,
	output logic     out_last
);

	tok_set_t set_q;
	tok_set_t set_next;
	logic     pop;

	assign out_valid = set_q.vld[0];
	assign out_tok = set_q.tok[0];
	assign out_last = set_q.vld[0] && !set_q.vld[1];
	assign pop = out_valid && out_ready;
	// free for a new load when empty or when this cycle drains the last entry
	assign empty_next = !set_q.vld[0] || (pop && !set_q.vld[1]);

	always_comb begin
		set_next = set_q;
		if (pop) begin
			set_next.vld = {1'b0, set_q.vld[MAX_RES-1:1]};
			set_next.tok = {set_q.tok[MAX_RES-1], set_q.tok[MAX_RES-1:1]};
		end
		if (load) set_next = set_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_q <= '0;
		end else begin
			set_q <= set_next;
		end
	end

endmodule

// File: tb/script_token_lexer_tb.sv
// ----------------------------------------------------------------------------
// script_token_lexer_tb
// Self-checking bench for the script token lexer. Source bytes are streamed in
// as requests; an in-bench lexer predicts every token, and each token taken
// from the output stream is compared field by field with the oldest one
// predicted. Directed sources cover operators, keywords, numbers, comments,
// errors and back-pressure, then random well-formed sources with noise follow.
// ----------------------------------------------------------------------------
module script_token_lexer_tb;
	import stl_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 20000;
	localparam logic [30:0] VALUE_TOP = 31'h7fffffff;
	localparam logic [19:0] LINE_TOP = '1;
	localparam logic [15:0] COLUMN_TOP = '1;

	localparam logic [5:0] KD_LET = 6'd2, KD_IF = 6'd3, KD_ELSE = 6'd4, KD_FOR = 6'd5,
		KD_IN = 6'd6, KD_WHILE = 6'd7, KD_BREAK = 6'd8, KD_CONTINUE = 6'd9,
		KD_RETURN = 6'd10, KD_NONE = 6'd11;
	localparam logic [5:0] KD_EQEQ = 6'd12, KD_NE = 6'd13, KD_LE = 6'd14, KD_GE = 6'd15,
		KD_ANDAND = 6'd16, KD_OROR = 6'd17, KD_PLUSEQ = 6'd18, KD_MINUSEQ = 6'd19;
	localparam logic [5:0] KD_SEMI = 6'd20, KD_LBRACE = 6'd21, KD_RBRACE = 6'd22,
		KD_LPAREN = 6'd23, KD_RPAREN = 6'd24, KD_DOT = 6'd25, KD_ASSIGN = 6'd26,
		KD_PLUS = 6'd27, KD_MINUS = 6'd28, KD_STAR = 6'd29, KD_SLASH = 6'd30,
		KD_PERCENT = 6'd31, KD_LT = 6'd32, KD_GT = 6'd33, KD_BANG = 6'd34;

	typedef struct packed {
		logic [5:0]  kind;
		logic [19:0] line;
		logic [15:0] col;
		logic [15:0] len;
		logic [30:0] value;
		logic        ovf;
		logic [7:0]  bad;
		logic        last;
	} token_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [7:0]   s_tdata;
	logic         s_tuser;
	logic         s_tlast;
	logic         m_tvalid;
	logic         m_tready;
	logic [95:0]  m_tdata;
	logic [5:0]   m_tuser;
	logic         m_tlast;

	script_token_lexer uut (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	token_t tok_q[$];
	int     mismatches = 0;
	int     items_sent = 0;
	int     idle_cycles = 0;
	int     hold_req = 0;
	int     stall_left = 0;
	bit     calm = 0;

	string       kw_text[13] = '{"let", "if", "else", "for", "in", "while", "break",
		"continue", "return", "none", "and", "or", "not"};
	logic [5:0]  kw_kind[13] = '{KD_LET, KD_IF, KD_ELSE, KD_FOR, KD_IN, KD_WHILE,
		KD_BREAK, KD_CONTINUE, KD_RETURN, KD_NONE, KD_ANDAND, KD_OROR, KD_BANG};

	// ---- lexer state mirror ----
	mode_t       lx_mode;
	logic [7:0]  lx_held;
	logic [19:0] cur_line, tok_line;
	logic [15:0] cur_col, tok_col, tok_len;
	logic [30:0] num_acc;
	logic        num_clamp;
	logic [7:0]  word_pre[8];

	function automatic bit digit_c(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit letter_c(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	task automatic lex_clear();
		lx_mode = M_IDLE;
		lx_held = '0;
		cur_line = 1;
		cur_col = 1;
		tok_line = 1;
		tok_col = 1;
		tok_len = 0;
		num_acc = 0;
		num_clamp = 0;
		foreach (word_pre[i]) word_pre[i] = '0;
	endtask

	task automatic add_token(logic [5:0] k, logic [19:0] ln, logic [15:0] cl,
			logic [15:0] n, logic [30:0] v, logic o, logic [7:0] b);
		token_t t;
		t = '{kind: k, line: ln, col: cl, len: n, value: v, ovf: o, bad: b, last: 1'b0};
		tok_q.insert(tok_q.size(), t);
	endtask

	task automatic advance(logic [7:0] c);
		if (c == 8'h0a) begin
			if (cur_line < LINE_TOP) cur_line++;
			cur_col = 1;
		end else if (cur_col < COLUMN_TOP) begin
			cur_col++;
		end
	endtask

	task automatic mark_token();
		tok_line = cur_line;
		tok_col = cur_col;
		tok_len = 1;
	endtask

	task automatic close_number();
		add_token(K_NUMBER, tok_line, tok_col, tok_len, num_acc, num_clamp, 8'h00);
	endtask

	task automatic close_word();
		logic [5:0] k;
		bit         hit;
		k = K_IDENT;
		for (int i = 0; i < 13; i++) begin
			if (k == K_IDENT && tok_len == kw_text[i].len()) begin
				hit = 1;
				for (int j = 0; j < kw_text[i].len(); j++)
					if (word_pre[j] != kw_text[i][j]) hit = 0;
				if (hit) k = kw_kind[i];
			end
		end
		add_token(k, tok_line, tok_col, tok_len, '0, 1'b0, 8'h00);
	endtask

	// lone operator; a lone & or | is an error and stops the source
	task automatic close_held();
		logic [5:0] k;
		case (lx_held)
			"=": k = KD_ASSIGN;
			"!": k = KD_BANG;
			"<": k = KD_LT;
			">": k = KD_GT;
			"+": k = KD_PLUS;
			"-": k = KD_MINUS;
			"/": k = KD_SLASH;
			default: k = K_ERROR;
		endcase
		if (k == K_ERROR) begin
			add_token(K_ERROR, tok_line, tok_col, 1, '0, 1'b0, lx_held);
			lx_mode = M_ERROR;
		end else begin
			add_token(k, tok_line, tok_col, 1, '0, 1'b0, 8'h00);
		end
	endtask

	task automatic begin_token(logic [7:0] c);
		logic [5:0] k;
		lx_mode = M_IDLE;
		if (c == " " || c == 8'h09 || c == 8'h0d || c == 8'h0a) begin
		end else if (digit_c(c)) begin
			mark_token();
			num_acc = c - "0";
			num_clamp = 0;
			lx_mode = M_NUMBER;
		end else if (letter_c(c)) begin
			mark_token();
			foreach (word_pre[i]) word_pre[i] = '0;
			word_pre[0] = c;
			lx_mode = M_IDENT;
		end else if (c == "=" || c == "!" || c == "<" || c == ">" || c == "&" ||
				c == "|" || c == "+" || c == "-" || c == "/") begin
			mark_token();
			lx_held = c;
			lx_mode = M_PEND;
		end else begin
			case (c)
				";": k = KD_SEMI;
				"{": k = KD_LBRACE;
				"}": k = KD_RBRACE;
				"(": k = KD_LPAREN;
				")": k = KD_RPAREN;
				".": k = KD_DOT;
				"*": k = KD_STAR;
				"%": k = KD_PERCENT;
				default: k = K_ERROR;
			endcase
			if (k == K_ERROR) begin
				add_token(K_ERROR, cur_line, cur_col, 1, '0, 1'b0, c);
				lx_mode = M_ERROR;
			end else begin
				add_token(k, cur_line, cur_col, 1, '0, 1'b0, 8'h00);
			end
		end
		advance(c);
	endtask

	task automatic lex_char(logic [7:0] c);
		logic [5:0]  k;
		logic [63:0] v;
		case (lx_mode)
			M_NUMBER: begin
				if (digit_c(c)) begin
					v = 64'(num_acc) * 10 + 64'(c - "0");
					if (v > 64'(VALUE_TOP)) begin
						v = 64'(VALUE_TOP);
						num_clamp = 1;
					end
					num_acc = v[30:0];
					if (tok_len < 16'hffff) tok_len++;
					advance(c);
				end else begin
					close_number();
					begin_token(c);
				end
			end
			M_IDENT: begin
				if (letter_c(c) || digit_c(c)) begin
					if (tok_len < 8) word_pre[tok_len] = c;
					if (tok_len < 16'hffff) tok_len++;
					advance(c);
				end else begin
					close_word();
					begin_token(c);
				end
			end
			M_PEND: begin
				k = 0;
				if (c == "=") begin
					case (lx_held)
						"=": k = KD_EQEQ;
						"!": k = KD_NE;
						"<": k = KD_LE;
						">": k = KD_GE;
						"+": k = KD_PLUSEQ;
						"-": k = KD_MINUSEQ;
						default: k = 0;
					endcase
				end else if (lx_held == "&" && c == "&") begin
					k = KD_ANDAND;
				end else if (lx_held == "|" && c == "|") begin
					k = KD_OROR;
				end
				if (k != 0) begin
					add_token(k, tok_line, tok_col, 2, '0, 1'b0, 8'h00);
					lx_mode = M_IDLE;
					advance(c);
				end else if (lx_held == "/" && c == "/") begin
					lx_mode = M_COMMENT;
					advance(c);
				end else begin
					lx_mode = M_IDLE;
					close_held();
					if (lx_mode == M_ERROR) advance(c);
					else begin_token(c);
				end
			end
			M_COMMENT, M_CSLASH: begin
				// a second // inside a comment ends it as well
				if (c == 8'h0a) lx_mode = M_IDLE;
				else if (c == "/") lx_mode = (lx_mode == M_CSLASH) ? M_IDLE : M_CSLASH;
				else lx_mode = M_COMMENT;
				advance(c);
			end
			M_ERROR: advance(c);
			default: begin_token(c);
		endcase
	endtask

	task automatic lex_request(logic [7:0] c, bit has, bit eos);
		int before_n;
		before_n = tok_q.size();
		if (has) lex_char(c);
		if (eos) begin
			if (lx_mode == M_NUMBER) close_number();
			else if (lx_mode == M_IDENT) close_word();
			else if (lx_mode == M_PEND) close_held();
			add_token(K_END, cur_line, cur_col, 0, '0, 1'b0, 8'h00);
			lex_clear();
		end
		if (tok_q.size() > before_n) tok_q[tok_q.size()-1].last = 1'b1;
	endtask

	// ---- stimulus side ----
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 70) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_request(logic [7:0] c, bit has, bit eos);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		s_tuser <= has;
		s_tlast <= eos;
		do @(posedge clk); while (!s_tready);
		lex_request(c, has, eos);
		items_sent++;
	endtask

	// text, closed by end of source on the last character
	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_request(s[i], 1'b1, i == s.len() - 1);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (tok_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic test_operators();
		send_text("==!=<=>=&&||+=-=;{}().=+-*/%<>!");
	endtask

	task automatic test_keywords();
		send_text("let if else for in while break continue return none and or not");
	endtask

	task automatic test_numbers();
		send_text("2147483647 2147483648");
	endtask

	task automatic test_comments();
		send_text("a//b/c//d\n1//x\n+");
		send_text("//c");
	endtask

	task automatic test_errors();
		send_text("&1");
		send_text("|x");
		send_text("a@b 9");
		send_request(8'hff, 1'b1, 1'b0);
		send_request(8'h00, 1'b1, 1'b0);
		send_request(8'ha5, 1'b0, 1'b0);
		send_request(8'h5a, 1'b0, 1'b1);
		send_request("x", 1'b0, 1'b1);
	endtask

	task automatic test_backpressure();
		hold_req = 400;
		@(posedge clk);
		for (int i = 0; i < 16; i++) send_request(i % 3 == 0 ? "+" : ";", 1'b1, i == 15);
	endtask

	function automatic byte rand_letter();
		int r;
		r = $urandom_range(0, 52);
		if (r < 26) return "a" + r;
		if (r < 52) return "A" + r - 26;
		return "_";
	endfunction

	task automatic test_random();
		byte     src[$];
		string   ops[23] = '{"==", "!=", "<=", ">=", "&&", "||", "+=", "-=", ";", "{", "}",
			"(", ")", ".", "=", "+", "-", "*", "/", "%", "<", ">", "!"};
		string   ws = " \t\r\n";
		string   s;
		int      ntok, cat, n;
		while (items_sent < 170) begin
			calm = ($urandom_range(0, 3) == 0);
			src.delete();
			ntok = $urandom_range(3, 8);
			for (int t = 0; t < ntok; t++) begin
				cat = $urandom_range(0, 99);
				if (cat < 20) begin
					s = kw_text[$urandom_range(0, 12)];
					foreach (s[i]) src.insert(src.size(), s[i]);
				end else if (cat < 35) begin
					n = $urandom_range(1, 10);
					src.insert(src.size(), rand_letter());
					for (int i = 1; i < n; i++)
						src.insert(src.size(), $urandom_range(0, 2) == 0 ?
							"0" + $urandom_range(0, 9) : rand_letter());
				end else if (cat < 52) begin
					n = $urandom_range(0, 3) == 0 ? $urandom_range(9, 12) : $urandom_range(1, 4);
					for (int i = 0; i < n; i++)
						src.insert(src.size(), "0" + $urandom_range(0, 9));
				end else if (cat < 80) begin
					s = ops[$urandom_range(0, 22)];
					foreach (s[i]) src.insert(src.size(), s[i]);
				end else if (cat < 92) begin
					src.insert(src.size(), "/");
					src.insert(src.size(), "/");
					n = $urandom_range(0, 6);
					for (int i = 0; i < n; i++) src.insert(src.size(), $urandom_range(0, 255));
					src.insert(src.size(), $urandom_range(0, 1) ? 8'h0a : "/");
					if (src[$] == "/") src.insert(src.size(), "/");
				end else begin
					src.insert(src.size(), $urandom_range(0, 255));
				end
				if ($urandom_range(0, 2) != 0) src.insert(src.size(), ws[$urandom_range(0, 3)]);
			end
			foreach (src[i]) begin
				if ($urandom_range(0, 19) == 0) send_request($urandom_range(0, 255), 1'b0, 1'b0);
				send_request(src[i], 1'b1, i == src.size() - 1 && $urandom_range(0, 1));
			end
			if (lx_mode != M_IDLE || cur_line != 1 || cur_col != 1)
				send_request($urandom_range(0, 255), 1'b0, 1'b1);
		end
		calm = 0;
	endtask

	// ---- result side ----
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_req != 0) begin
			stall_left = hold_req;
			hold_req = 0;
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (calm) begin
			m_tready <= 1'b1;
		end else if ($urandom_range(0, 99) < 3) begin
			stall_left = $urandom_range(10, 40);
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 9) < 7);
		end
	end

	always @(posedge clk) begin
		token_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.kind = m_tuser;
			got.line = m_tdata[19:0];
			got.col = m_tdata[35:20];
			got.len = m_tdata[51:36];
			got.value = m_tdata[82:52];
			got.ovf = m_tdata[83];
			got.bad = m_tdata[91:84];
			got.last = m_tlast;
			if (tok_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected token: kind %0d line %0d col %0d", got.kind,
						got.line, got.col);
			end else begin
				want = tok_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("token mismatch exp: kind %0d line %0d col %0d len %0d val %0d ovf %0b bad %0h last %0b",
							want.kind, want.line, want.col, want.len, want.value, want.ovf,
							want.bad, want.last);
						$display("               got: kind %0d line %0d col %0d len %0d val %0d ovf %0b bad %0h last %0b",
							got.kind, got.line, got.col, got.len, got.value, got.ovf,
							got.bad, got.last);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("script_token_lexer_tb: FAIL");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		s_tlast = 1'b0;
		lex_clear();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_operators();
		test_keywords();
		test_numbers();
		test_comments();
		test_errors();
		settle();
		test_backpressure();
		test_random();
		settle();
		if (mismatches == 0 && tok_q.size() == 0) begin
			$display("script_token_lexer_tb: PASS");
		end else begin
			$display("script_token_lexer_tb: FAIL");
		end
		$finish;
	end

endmodule

// File: script_token_lexer.f
hdl/stl_pkg.sv
hdl/stl_out_queue.sv
hdl/script_token_lexer.sv
tb/script_token_lexer_tb.sv
